[hdl/drfu_pkg.sv]
// Shared types, constants and request codes for the dirty-rectangle updater.
`timescale 1ns / 1ps
package drfu_pkg;

  localparam int unsigned DispWidthDef  = 160;
  localparam int unsigned DispHeightDef = 128;
  localparam int unsigned BytesPerPixDef = 2;

  localparam logic [7:0] CmdCaset = 8'h2a;
  localparam logic [7:0] CmdRaset = 8'h2b;
  localparam logic [7:0] CmdRamwr = 8'h2c;

  typedef enum logic [2:0] {
    REQ_FG_PIX  = 3'd0,
    REQ_BG_PIX  = 3'd1,
    REQ_COL_PIX = 3'd2,
    REQ_BG_RECT = 3'd3,
    REQ_FILL    = 3'd4,
    REQ_REFRESH = 3'd5,
    REQ_PULL    = 3'd6,
    REQ_NONE    = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    CFG_X_OFFSET   = 3'd0,
    CFG_Y_OFFSET   = 3'd1,
    CFG_FULL_X_END = 3'd2,
    CFG_FULL_Y_END = 3'd3,
    CFG_FG_COLOUR  = 3'd4,
    CFG_BG_COLOUR  = 3'd5
  } cfg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RECT,
    ST_FILL
  } back_st_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [23:0] pixel_colour;
  } req_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] out_byte;
    logic       last;
  } rsp_t;

  // Queued operation for the back part.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [8:0]  x_end;
    logic [8:0]  y_end;
    logic [23:0] colour;
  } op_t;

endpackage

[hdl/drfu_front.sv]
// Front part: classifies requests, clips rectangles and resolves colours.
`timescale 1ns / 1ps
module drfu_front #(
  parameter int unsigned DispWidth  = drfu_pkg::DispWidthDef,
  parameter int unsigned DispHeight = drfu_pkg::DispHeightDef
) (
  input  drfu_pkg::req_t req_i,
  input  logic [23:0]    fg_colour_i,
  input  logic [23:0]    bg_colour_i,
  output drfu_pkg::op_t  op_o
);

  logic [8:0] x_sum, y_sum;

  always_comb begin
    x_sum = {1'b0, req_i.pos_x} + {1'b0, req_i.rect_width};
    y_sum = {1'b0, req_i.pos_y} + {1'b0, req_i.rect_height};
    op_o.kind  = req_i.req_type;
    op_o.pos_x = req_i.pos_x;
    op_o.pos_y = req_i.pos_y;
    op_o.x_end = (x_sum > 9'(DispWidth)) ? 9'(DispWidth) : x_sum;
    op_o.y_end = (y_sum > 9'(DispHeight)) ? 9'(DispHeight) : y_sum;
    case (drfu_pkg::req_e'(req_i.req_type))
      drfu_pkg::REQ_FG_PIX, drfu_pkg::REQ_FILL: op_o.colour = fg_colour_i;
      drfu_pkg::REQ_COL_PIX:                    op_o.colour = req_i.pixel_colour;
      default:                                  op_o.colour = bg_colour_i;
    endcase
  end

endmodule

[hdl/drfu_queue.sv]
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module drfu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  drfu_pkg::op_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          empty_o,
  output drfu_pkg::op_t rdata_o
);

  drfu_pkg::op_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q + 2'(wr_i) - 2'(rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i || rd_i) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !rd_i) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count");

endmodule

[hdl/drfu_back.sv]
// Back part: framebuffer, dirty box, fills and display byte sequencer.
`timescale 1ns / 1ps
module drfu_back #(
  parameter int unsigned DispWidth   = drfu_pkg::DispWidthDef,
  parameter int unsigned DispHeight  = drfu_pkg::DispHeightDef,
  parameter int unsigned BytesPerPix = drfu_pkg::BytesPerPixDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  drfu_pkg::op_t op_i,
  output logic          op_take_o,
  input  logic [7:0]    x_offset_i,
  input  logic [7:0]    y_offset_i,
  input  logic [7:0]    full_x_end_i,
  input  logic [7:0]    full_y_end_i,
  output logic          rsp_valid_o,
  output drfu_pkg::rsp_t rsp_o,
  input  logic          rsp_pop_i
);

  localparam int unsigned Depth  = DispWidth * DispHeight;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned PixW   = 8 * BytesPerPix;
  localparam int unsigned BiW    = $clog2(BytesPerPix);
  localparam int unsigned PhIdle = 0;
  localparam int unsigned PhPix  = 12;

  logic [PixW-1:0] mem [Depth];

  drfu_pkg::back_st_e st_q, st_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [8:0] cx_q, cx_d, cy_q, cy_d;
  logic [PixW-1:0] fcol_q, fcol_d;
  logic [8:0] rxs_q, rxs_d, rxe_q, rxe_d, rye_q, rye_d;

  logic dirty_q, dirty_d, all_q, all_d;
  logic [7:0] bx0_q, bx0_d, bx1_q, bx1_d, by0_q, by0_d, by1_q, by1_d;
  logic [7:0] wx0_q, wx0_d, wx1_q, wx1_d, wy0_q, wy0_d, wy1_q, wy1_d;
  logic [7:0] h0_q, h0_d, h1_q, h1_d, h2_q, h2_d, h3_q, h3_d;
  logic [3:0] ph_q, ph_d;
  logic [7:0] px_q, px_d, py_q, py_d;
  logic [BiW-1:0] bi_q, bi_d;

  // Output stage: one pending read result, then the result register.
  logic       rd_pend_q, rd_pend_d;
  logic       rd_hdr_q;
  logic [7:0] rd_hb_q;
  logic       rd_cmd_q, rd_last_q, rd_zero_q;
  logic [BiW-1:0] rd_bi_q;
  logic [PixW-1:0] rd_data_q;
  logic       ov_q;
  drfu_pkg::rsp_t ob_q;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [PixW-1:0] wdata;
  logic re;
  logic pp_en;
  logic [7:0] pp_x, pp_y;
  logic out_free;
  logic pull_ok;
  logic hdr_cmd;
  logic [7:0] hdr_byte;
  logic is_last;
  logic [PixW-1:0] sh;

  assign out_free = !ov_q || rsp_pop_i;
  assign rsp_valid_o = ov_q;
  assign rsp_o = ob_q;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      drfu_pkg::ST_CLEAR: if (clr_q == AddrW'(Depth - 1)) st_d = drfu_pkg::ST_IDLE;
      drfu_pkg::ST_IDLE: begin
        if (op_valid_i && !rd_pend_q) begin
          if (op_i.kind == drfu_pkg::REQ_BG_RECT
              && {1'b0, op_i.pos_x} < op_i.x_end && {1'b0, op_i.pos_y} < op_i.y_end)
            st_d = drfu_pkg::ST_RECT;
          else if (op_i.kind == drfu_pkg::REQ_FILL) st_d = drfu_pkg::ST_FILL;
        end
      end
      drfu_pkg::ST_RECT:
        if (cx_q + 9'd1 >= rxe_q && cy_q + 9'd1 >= rye_q) st_d = drfu_pkg::ST_IDLE;
      drfu_pkg::ST_FILL: if (clr_q == AddrW'(Depth - 1)) st_d = drfu_pkg::ST_IDLE;
      default: st_d = drfu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (ph_q)
      4'd1: begin hdr_cmd = 1'b1; hdr_byte = drfu_pkg::CmdCaset; end
      4'd6: begin hdr_cmd = 1'b1; hdr_byte = drfu_pkg::CmdRaset; end
      4'd11: begin hdr_cmd = 1'b1; hdr_byte = drfu_pkg::CmdRamwr; end
      4'd3: begin hdr_cmd = 1'b0; hdr_byte = h0_q; end
      4'd5: begin hdr_cmd = 1'b0; hdr_byte = h1_q; end
      4'd8: begin hdr_cmd = 1'b0; hdr_byte = h2_q; end
      4'd10: begin hdr_cmd = 1'b0; hdr_byte = h3_q; end
      default: begin hdr_cmd = 1'b0; hdr_byte = 8'd0; end
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    clr_d = clr_q; cx_d = cx_q; cy_d = cy_q; fcol_d = fcol_q;
    rxs_d = rxs_q; rxe_d = rxe_q; rye_d = rye_q;
    dirty_d = dirty_q; all_d = all_q;
    bx0_d = bx0_q; bx1_d = bx1_q; by0_d = by0_q; by1_d = by1_q;
    wx0_d = wx0_q; wx1_d = wx1_q; wy0_d = wy0_q; wy1_d = wy1_q;
    h0_d = h0_q; h1_d = h1_q; h2_d = h2_q; h3_d = h3_q;
    ph_d = ph_q; px_d = px_q; py_d = py_q; bi_d = bi_q;
    rd_pend_d = 1'b0;
    op_take_o = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0;
    re = 1'b0; raddr = '0;
    pp_en = 1'b0; pp_x = '0; pp_y = '0;
    pull_ok = 1'b0;
    is_last = 1'b0;
    unique case (st_q)
      drfu_pkg::ST_CLEAR: begin
        we = 1'b1; waddr = clr_q; clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) clr_d = '0;
      end
      drfu_pkg::ST_FILL: begin
        we = 1'b1; waddr = clr_q; wdata = fcol_q; clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) clr_d = '0;
      end
      drfu_pkg::ST_RECT: begin
        pp_en = 1'b1; pp_x = cx_q[7:0]; pp_y = cy_q[7:0];
        wdata = fcol_q;
        if (cx_q + 9'd1 >= rxe_q) begin
          cx_d = rxs_q; cy_d = cy_q + 9'd1;
        end else begin
          cx_d = cx_q + 9'd1;
        end
      end
      drfu_pkg::ST_IDLE: begin
        if (op_valid_i && !rd_pend_q) begin
          case (drfu_pkg::req_e'(op_i.kind))
            drfu_pkg::REQ_FG_PIX, drfu_pkg::REQ_BG_PIX, drfu_pkg::REQ_COL_PIX: begin
              op_take_o = 1'b1;
              pp_en = 1'b1; pp_x = op_i.pos_x; pp_y = op_i.pos_y;
              wdata = op_i.colour[PixW-1:0];
            end
            drfu_pkg::REQ_BG_RECT: begin
              op_take_o = 1'b1;
              cx_d = {1'b0, op_i.pos_x}; cy_d = {1'b0, op_i.pos_y};
              rxs_d = {1'b0, op_i.pos_x}; rxe_d = op_i.x_end; rye_d = op_i.y_end;
              fcol_d = op_i.colour[PixW-1:0];
            end
            drfu_pkg::REQ_FILL: begin
              op_take_o = 1'b1; fcol_d = op_i.colour[PixW-1:0];
              all_d = 1'b1; clr_d = '0;
            end
            drfu_pkg::REQ_REFRESH: begin
              op_take_o = 1'b1;
              if (ph_q == 4'(PhIdle) && (all_q || dirty_q)) begin
                ph_d = 4'd1; px_d = all_q ? 8'd0 : bx0_q;
                py_d = all_q ? 8'd0 : by0_q; bi_d = '0;
                if (all_q) begin
                  all_d = 1'b0; dirty_d = 1'b0;
                  wx0_d = 8'd0; wx1_d = 8'(DispWidth - 1);
                  wy0_d = 8'd0; wy1_d = 8'(DispHeight - 1);
                  h0_d = x_offset_i; h1_d = full_x_end_i;
                  h2_d = y_offset_i; h3_d = full_y_end_i;
                end else begin
                  dirty_d = 1'b0;
                  wx0_d = bx0_q; wx1_d = bx1_q; wy0_d = by0_q; wy1_d = by1_q;
                  h0_d = bx0_q + x_offset_i; h1_d = bx1_q + x_offset_i;
                  h2_d = by0_q + y_offset_i; h3_d = by1_q + y_offset_i;
                end
              end
            end
            drfu_pkg::REQ_PULL: begin
              if (ph_q == 4'(PhIdle)) begin
                op_take_o = 1'b1;
              end else if (out_free) begin
                op_take_o = 1'b1; pull_ok = 1'b1; rd_pend_d = 1'b1;
                if (ph_q != 4'(PhPix)) begin
                  ph_d = ph_q + 4'd1;
                end else begin
                  re = 1'b1;
                  raddr = AddrW'(32'(py_q) * DispWidth + 32'(px_q));
                  is_last = bi_q == BiW'(BytesPerPix - 1) && px_q == wx1_q && py_q == wy1_q;
                  if (bi_q != BiW'(BytesPerPix - 1)) begin
                    bi_d = bi_q + BiW'(1);
                  end else begin
                    bi_d = '0;
                    if (px_q == wx1_q) begin
                      px_d = wx0_q; py_d = py_q + 8'd1;
                    end else begin
                      px_d = px_q + 8'd1;
                    end
                  end
                  if (is_last) ph_d = 4'(PhIdle);
                end
              end
            end
            default: op_take_o = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    if (pp_en && {1'b0, pp_x} < 9'(DispWidth) && {1'b0, pp_y} < 9'(DispHeight)) begin
      we = 1'b1;
      waddr = AddrW'(32'(pp_y) * DispWidth + 32'(pp_x));
      if (!dirty_d) begin
        dirty_d = 1'b1; bx0_d = pp_x; bx1_d = pp_x; by0_d = pp_y; by1_d = pp_y;
      end else begin
        if (pp_x < bx0_d) bx0_d = pp_x;
        if (pp_x > bx1_d) bx1_d = pp_x;
        if (pp_y < by0_d) by0_d = pp_y;
        if (pp_y > by1_d) by1_d = pp_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_data_q <= mem[raddr];
  end

  always_comb begin
    sh = rd_data_q >> (8 * (BytesPerPix - 1 - int'(rd_bi_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= drfu_pkg::ST_CLEAR; clr_q <= '0; cx_q <= '0; cy_q <= '0;
      fcol_q <= '0; rxs_q <= '0; rxe_q <= '0; rye_q <= '0;
      dirty_q <= 1'b0; all_q <= 1'b0;
      bx0_q <= '0; bx1_q <= '0; by0_q <= '0; by1_q <= '0;
      wx0_q <= '0; wx1_q <= '0; wy0_q <= '0; wy1_q <= '0;
      h0_q <= '0; h1_q <= '0; h2_q <= '0; h3_q <= '0;
      ph_q <= '0; px_q <= '0; py_q <= '0; bi_q <= '0;
      rd_pend_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; cx_q <= cx_d; cy_q <= cy_d;
      fcol_q <= fcol_d; rxs_q <= rxs_d; rxe_q <= rxe_d; rye_q <= rye_d;
      dirty_q <= dirty_d; all_q <= all_d;
      bx0_q <= bx0_d; bx1_q <= bx1_d; by0_q <= by0_d; by1_q <= by1_d;
      wx0_q <= wx0_d; wx1_q <= wx1_d; wy0_q <= wy0_d; wy1_q <= wy1_d;
      h0_q <= h0_d; h1_q <= h1_d; h2_q <= h2_d; h3_q <= h3_d;
      ph_q <= ph_d; px_q <= px_d; py_q <= py_d; bi_q <= bi_d;
      rd_pend_q <= rd_pend_d;
      if (rd_pend_q) ov_q <= 1'b1;
      else if (rsp_pop_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pull_ok) begin
      rd_hdr_q <= ph_q != 4'(PhPix);
      rd_cmd_q <= hdr_cmd; rd_hb_q <= hdr_byte;
      rd_last_q <= is_last; rd_bi_q <= bi_q;
      rd_zero_q <= 1'b0;
    end
    if (rd_pend_q) begin
      ob_q.is_data  <= !(rd_hdr_q && rd_cmd_q);
      ob_q.out_byte <= (rd_hdr_q || rd_zero_q) ? rd_hb_q : sh[7:0];
      ob_q.last     <= !rd_hdr_q && rd_last_q;
    end
  end

  a_pend_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !$past(ov_q) || $past(rsp_pop_i) || !$past(rd_pend_q))
    else $error("result overwritten");
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != drfu_pkg::ST_IDLE |-> !op_take_o) else $error("take while busy");
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q <= 4'(PhPix)) else $error("phase range");

endmodule

[hdl/dirty_rect_framebuffer_updater.sv]
// Top level of the dirty-rectangle framebuffer updater.
//  channel | dir | handshake        | payload
//  request | in  | push / full      | req_i (req_t)
//  result  | out | pop / empty      | rsp_o (rsp_t)
//  config  | in  | cfg_we_i          | cfg_idx_i, cfg_data_i
// Pixel writes and refreshes are taken in the idle state. A pull during a refresh stalls
// the next operation while its read is pending, then its word enters the result register;
// a pull with no refresh yields no word. A rectangle holds the back part for each clipped
// pixel, a fill for every entry. After reset a pass zeroes the framebuffer; the two-word
// queue may fill and raise full meanwhile. A pull waits while a word sits unpopped.
`timescale 1ns / 1ps
module dirty_rect_framebuffer_updater #(
  parameter int unsigned DispWidth   = drfu_pkg::DispWidthDef,
  parameter int unsigned DispHeight  = drfu_pkg::DispHeightDef,
  parameter int unsigned BytesPerPix = drfu_pkg::BytesPerPixDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  drfu_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output drfu_pkg::rsp_t rsp_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [23:0]    cfg_data_i
);

  logic [7:0]  x_off_q, y_off_q, fxe_q, fye_q;
  logic [23:0] fg_q, bg_q;
  drfu_pkg::op_t fop, qop;
  logic q_empty, take, vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q <= 8'd1; y_off_q <= 8'd2; fxe_q <= 8'd160; fye_q <= 8'd129;
      fg_q <= '0; bg_q <= '0;
    end else if (cfg_we_i) begin
      case (drfu_pkg::cfg_e'(cfg_idx_i))
        drfu_pkg::CFG_X_OFFSET:   x_off_q <= cfg_data_i[7:0];
        drfu_pkg::CFG_Y_OFFSET:   y_off_q <= cfg_data_i[7:0];
        drfu_pkg::CFG_FULL_X_END: fxe_q <= cfg_data_i[7:0];
        drfu_pkg::CFG_FULL_Y_END: fye_q <= cfg_data_i[7:0];
        drfu_pkg::CFG_FG_COLOUR:  fg_q <= cfg_data_i;
        drfu_pkg::CFG_BG_COLOUR:  bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  drfu_front #(.DispWidth(DispWidth), .DispHeight(DispHeight)) u_front (
    .req_i(req_i), .fg_colour_i(fg_q), .bg_colour_i(bg_q), .op_o(fop));

  drfu_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .wr_i(push && !full), .wdata_i(fop),
    .full_o(full), .rd_i(take), .empty_o(q_empty), .rdata_o(qop));

  drfu_back #(.DispWidth(DispWidth), .DispHeight(DispHeight),
    .BytesPerPix(BytesPerPix)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .op_valid_i(!q_empty), .op_i(qop),
    .op_take_o(take), .x_offset_i(x_off_q), .y_offset_i(y_off_q),
    .full_x_end_i(fxe_q), .full_y_end_i(fye_q),
    .rsp_valid_o(vld), .rsp_o(rsp_o), .rsp_pop_i(pop && vld));

  assign empty = !vld;

  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !q_empty) else $error("take from empty queue");
  a_pop_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !$past(take) |=> empty) else $error("stale result");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !take |=> full) else $error("queue lost word");

endmodule
